@@ sv/dfs_pkg.sv @@
// Shared types and constants of the depth-first maze carver.
// Holds command/result payload structs, operation and direction codes, wall bits.
// No dependencies.
package dfs_pkg;

    // command payload
    typedef struct packed {
        logic [1:0]  operation;
        logic [14:0] random_word;
        logic [3:0]  cell_row;
        logic [3:0]  cell_col;
    } dfs_cmd_t;

    // result payload
    typedef struct packed {
        logic        carved;
        logic        finished;
        logic [3:0]  from_row;
        logic [3:0]  from_col;
        logic [1:0]  direction;
        logic [3:0]  wall_code;
    } dfs_res_t;

    // neighbour choice handed from the picker to the control
    typedef struct packed {
        logic       any;
        logic [1:0] dir;
    } dfs_pick_t;

    // operations
    localparam logic [1:0] OP_STEP    = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // directions, also the order in which neighbours are listed
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_S = 2'd1;
    localparam logic [1:0] DIR_E = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    // wall bits and codes
    localparam logic [3:0] WALL_N     = 4'd8;
    localparam logic [3:0] WALL_S     = 4'd4;
    localparam logic [3:0] WALL_E     = 4'd2;
    localparam logic [3:0] WALL_W     = 4'd1;
    localparam logic [3:0] WALL_ALL   = 4'd15;
    localparam logic [3:0] WALL_START = 4'd7;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // wall of the source cell facing a direction
    function automatic logic [3:0] own_bit(input logic [1:0] dir);
        logic [3:0] b;
        case (dir)
            DIR_N:   b = WALL_N;
            DIR_S:   b = WALL_S;
            DIR_E:   b = WALL_E;
            default: b = WALL_W;
        endcase
        return b;
    endfunction

    // wall of the neighbour facing back to the source
    function automatic logic [3:0] far_bit(input logic [1:0] dir);
        logic [3:0] b;
        case (dir)
            DIR_N:   b = WALL_S;
            DIR_S:   b = WALL_N;
            DIR_E:   b = WALL_W;
            default: b = WALL_E;
        endcase
        return b;
    endfunction

endpackage

@@ sv/dfs_maze_carver.sv @@
// Top level of the depth-first maze carver: control sequencer, wall grid and path stack.
// Uses dfs_pkg for payload types and codes, dfs_pick for the neighbour choice.
//
// The maze lives in a wall-grid memory (4-bit code per cell) and a path-stack memory,
// both with registered reads, stepped by one sequencer, one command at a time.
// A read fetches one cell, a restart sweeps the grid, and a carve step reads the stack
// top, probes the grid and writes the source and neighbour codes, repeating read and
// probe for each cell popped while backtracking; the finishing step reads the last cell
// and opens its exit once. The single read port of the grid fetches the four neighbours
// and the source cell one per cycle. After reset the block sweeps the grid to its start
// codes and accepts no command until done; configuration writes are taken at any time.
// One result register sits on the output, so a command is taken while a result waits.
module dfs_maze_carver #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  dfs_pkg::dfs_cmd_t cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output dfs_pkg::dfs_res_t res,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [4:0]        cfg_data
);

    localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW        = RW + CW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int NCELLS    = MAX_ROWS * MAX_COLS;
    localparam int SW        = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int CNT_W     = $clog2(NCELLS + 1);
    localparam int RB        = $clog2(MAX_ROWS + 1);
    localparam int CB        = $clog2(MAX_COLS + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLR      = 4'd1;
    localparam logic [3:0] S_TOP      = 4'd2;
    localparam logic [3:0] S_TOP_WAIT = 4'd3;
    localparam logic [3:0] S_PROBE    = 4'd4;
    localparam logic [3:0] S_CHOOSE   = 4'd5;
    localparam logic [3:0] S_WR_NBR   = 4'd6;
    localparam logic [3:0] S_FIN_RD   = 4'd7;
    localparam logic [3:0] S_FIN_WB   = 4'd8;
    localparam logic [3:0] S_RD       = 4'd9;
    localparam logic [3:0] S_RD_WB    = 4'd10;
    localparam logic [3:0] S_OUT      = 4'd11;

    localparam logic [2:0] PROBE_SELF = 3'd4;

    // control registers
    logic [3:0]       state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [2:0]       probe_reg, probe_next;
    logic [3:0]       flags_reg, flags_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             exit_reg, exit_next;
    logic             pend_reg, pend_next;
    logic             res_valid_reg, res_valid_next;
    logic [4:0]       rows_cfg_reg, cols_cfg_reg;

    // payload registers
    logic [AW-1:0]     cur_reg, cur_next;
    logic [AW-1:0]     nbr_reg, nbr_next;
    logic [1:0]        dir_reg, dir_next;
    logic [3:0]        own_reg, own_next;
    dfs_pkg::dfs_cmd_t cmd_reg, cmd_next;
    dfs_pkg::dfs_res_t hold_reg, hold_next;
    dfs_pkg::dfs_res_t res_reg, res_next;

    // memory ports
    logic [3:0]    wall_mem [MEM_DEPTH];
    logic          wall_we;
    logic [AW-1:0] wall_waddr;
    logic [3:0]    wall_wdata;
    logic [AW-1:0] wall_raddr;
    logic [3:0]    wall_q;
    logic [AW-1:0] stk_mem [NCELLS];
    logic          stk_we;
    logic [SW-1:0] stk_waddr;
    logic [AW-1:0] stk_wdata;
    logic [SW-1:0] stk_raddr;
    logic [AW-1:0] stk_q;

    // derived values
    logic [RB-1:0]    rows_eff, rows_dec;
    logic [CB-1:0]    cols_eff, cols_dec;
    logic [RW-1:0]    cur_r;
    logic [CW-1:0]    cur_c;
    logic [AW-1:0]    nb_addr [4];
    logic [3:0]       inb;
    logic [2:0]       prb_dec;
    logic [CNT_W-1:0] cnt_dec;
    logic [AW-1:0]    last_addr;
    logic             rd_ok;
    logic             out_free;
    dfs_pkg::dfs_pick_t pick;

    assign cfg_ready = 1'b1;
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign out_free  = !res_valid_reg || res_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= 5'd16;
            cols_cfg_reg <= 5'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dfs_pkg::CFG_ROWS: rows_cfg_reg <= cfg_data;
                default:           cols_cfg_reg <= cfg_data;
            endcase
        end
    end

    // clamp the bounds into 1..MAX
    always_comb
    begin
        if (rows_cfg_reg == 5'd0)
            rows_eff = RB'(1);
        else if (32'(rows_cfg_reg) > MAX_ROWS)
            rows_eff = RB'(MAX_ROWS);
        else
            rows_eff = RB'(rows_cfg_reg);
        if (cols_cfg_reg == 5'd0)
            cols_eff = CB'(1);
        else if (32'(cols_cfg_reg) > MAX_COLS)
            cols_eff = CB'(MAX_COLS);
        else
            cols_eff = CB'(cols_cfg_reg);
    end

    assign rows_dec  = rows_eff - RB'(1);
    assign cols_dec  = cols_eff - CB'(1);
    assign last_addr = {rows_dec[RW-1:0], cols_dec[CW-1:0]};

    // neighbour addresses and bounds of the current cell
    assign cur_r      = cur_reg[AW-1:CW];
    assign cur_c      = cur_reg[CW-1:0];
    assign nb_addr[0] = {cur_r - RW'(1), cur_c};
    assign nb_addr[1] = {cur_r + RW'(1), cur_c};
    assign nb_addr[2] = {cur_r, cur_c + CW'(1)};
    assign nb_addr[3] = {cur_r, cur_c - CW'(1)};
    assign inb[0]     = (cur_r != '0);
    assign inb[1]     = (32'(cur_r) + 1 < 32'(rows_eff));
    assign inb[2]     = (32'(cur_c) + 1 < 32'(cols_eff));
    assign inb[3]     = (cur_c != '0);

    assign prb_dec = probe_reg - 3'd1;
    assign cnt_dec = count_reg - CNT_W'(1);
    assign rd_ok   = (32'(cmd_reg.cell_row) < MAX_ROWS) && (32'(cmd_reg.cell_col) < MAX_COLS);

    dfs_pick u_pick (
        .avail (flags_reg),
        .word  (cmd_reg.random_word),
        .pick  (pick)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        probe_next     = probe_reg;
        flags_next     = flags_reg;
        count_next     = count_reg;
        exit_next      = exit_reg;
        pend_next      = pend_reg;
        cur_next       = cur_reg;
        nbr_next       = nbr_reg;
        dir_next       = dir_reg;
        own_next       = own_reg;
        cmd_next       = cmd_reg;
        hold_next      = hold_reg;
        wall_we        = 1'b0;
        wall_waddr     = cur_reg;
        wall_wdata     = dfs_pkg::WALL_ALL;
        wall_raddr     = cur_reg;
        stk_we         = 1'b0;
        stk_waddr      = count_reg[SW-1:0];
        stk_wdata      = nbr_reg;
        stk_raddr      = cnt_dec[SW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    case (cmd.operation)
                        dfs_pkg::OP_STEP:    state_next = S_TOP;
                        dfs_pkg::OP_READ:    state_next = S_RD;
                        dfs_pkg::OP_RESTART:
                        begin
                            pend_next  = 1'b1;
                            clr_next   = '0;
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            hold_next          = '0;
                            hold_next.finished = (count_reg == '0);
                            state_next         = S_OUT;
                        end
                    endcase
                end
            end

            // grid sweep to start codes, stack back to cell zero
            S_CLR:
            begin
                wall_we    = 1'b1;
                wall_waddr = clr_reg;
                wall_wdata = (clr_reg == '0) ? dfs_pkg::WALL_START : dfs_pkg::WALL_ALL;
                if (clr_reg == '0)
                begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = '0;
                end
                count_next = CNT_W'(1);
                exit_next  = 1'b0;
                clr_next   = clr_reg + AW'(1);
                if (clr_reg == AW'(MEM_DEPTH - 1))
                begin
                    if (pend_reg)
                    begin
                        hold_next           = '0;
                        hold_next.wall_code = dfs_pkg::WALL_START;
                        state_next          = S_OUT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                    pend_next = 1'b0;
                end
            end

            // top of stack fetch, or finish when empty
            S_TOP:
            begin
                if (count_reg == '0)
                    state_next = S_FIN_RD;
                else
                    state_next = S_TOP_WAIT;
            end

            S_TOP_WAIT:
            begin
                cur_next   = stk_q;
                probe_next = '0;
                flags_next = '0;
                state_next = S_PROBE;
            end

            // one grid read a cycle: N, S, E, W, then the cell itself
            S_PROBE:
            begin
                case (probe_reg)
                    3'd0:    wall_raddr = nb_addr[0];
                    3'd1:    wall_raddr = nb_addr[1];
                    3'd2:    wall_raddr = nb_addr[2];
                    3'd3:    wall_raddr = nb_addr[3];
                    default: wall_raddr = cur_reg;
                endcase
                if (probe_reg != '0)
                begin
                    flags_next[prb_dec[1:0]] = inb[prb_dec[1:0]] && (wall_q == dfs_pkg::WALL_ALL);
                end
                if (probe_reg == PROBE_SELF)
                    state_next = S_CHOOSE;
                else
                    probe_next = probe_reg + 3'd1;
            end

            // own code arrives now: carve the source wall or pop
            S_CHOOSE:
            begin
                if (!pick.any)
                begin
                    count_next = cnt_dec;
                    state_next = S_TOP;
                end
                else
                begin
                    wall_we    = 1'b1;
                    wall_waddr = cur_reg;
                    wall_wdata = wall_q & ~dfs_pkg::own_bit(pick.dir);
                    own_next   = wall_q & ~dfs_pkg::own_bit(pick.dir);
                    dir_next   = pick.dir;
                    nbr_next   = nb_addr[pick.dir];
                    state_next = S_WR_NBR;
                end
            end

            // neighbour was unvisited, so its new code is known
            S_WR_NBR:
            begin
                wall_we    = 1'b1;
                wall_waddr = nbr_reg;
                wall_wdata = dfs_pkg::WALL_ALL & ~dfs_pkg::far_bit(dir_reg);
                if (32'(count_reg) < NCELLS)
                begin
                    stk_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                hold_next.carved    = 1'b1;
                hold_next.finished  = 1'b0;
                hold_next.from_row  = 4'(cur_r);
                hold_next.from_col  = 4'(cur_c);
                hold_next.direction = dir_reg;
                hold_next.wall_code = own_reg;
                state_next          = S_OUT;
            end

            S_FIN_RD:
            begin
                wall_raddr = last_addr;
                state_next = S_FIN_WB;
            end

            // open the exit once
            S_FIN_WB:
            begin
                hold_next.carved    = 1'b0;
                hold_next.finished  = 1'b1;
                hold_next.from_row  = 4'(rows_dec);
                hold_next.from_col  = 4'(cols_dec);
                hold_next.direction = dfs_pkg::DIR_S;
                hold_next.wall_code = wall_q;
                if (!exit_reg)
                begin
                    wall_we             = 1'b1;
                    wall_waddr          = last_addr;
                    wall_wdata          = wall_q & ~dfs_pkg::WALL_S;
                    hold_next.wall_code = wall_q & ~dfs_pkg::WALL_S;
                    exit_next           = 1'b1;
                end
                state_next = S_OUT;
            end

            S_RD:
            begin
                wall_raddr = {RW'(cmd_reg.cell_row), CW'(cmd_reg.cell_col)};
                state_next = S_RD_WB;
            end

            S_RD_WB:
            begin
                hold_next.carved    = 1'b0;
                hold_next.finished  = (count_reg == '0);
                hold_next.from_row  = cmd_reg.cell_row;
                hold_next.from_col  = cmd_reg.cell_col;
                hold_next.direction = dfs_pkg::DIR_N;
                hold_next.wall_code = rd_ok ? wall_q : 4'd0;
                state_next          = S_OUT;
            end

            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;
        if (state_reg == S_OUT && out_free)
        begin
            res_valid_next = 1'b1;
            res_next       = hold_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            probe_reg     <= '0;
            flags_reg     <= '0;
            count_reg     <= CNT_W'(1);
            exit_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            probe_reg     <= probe_next;
            flags_reg     <= flags_next;
            count_reg     <= count_next;
            exit_reg      <= exit_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        nbr_reg  <= nbr_next;
        dir_reg  <= dir_next;
        own_reg  <= own_next;
        cmd_reg  <= cmd_next;
        hold_reg <= hold_next;
        res_reg  <= res_next;
    end

    // wall grid memory
    always_ff @(posedge clk)
    begin
        if (wall_we)
            wall_mem[wall_waddr] <= wall_wdata;
        wall_q <= wall_mem[wall_raddr];
    end

    // path stack memory
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        stk_q <= stk_mem[stk_raddr];
    end

    // stack never holds more than every cell once
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= NCELLS)
        else $error("path stack count beyond cell count");

    // a carving result is never a finishing result
    a_carve_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.carved && res_reg.finished))
        else $error("result both carved and finished");

    // the chosen direction is an open neighbour
    a_pick_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHOOSE && pick.any) |-> flags_reg[pick.dir])
        else $error("picked a closed neighbour");

    // a carve always pushes the neighbour
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR_NBR) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("carve without push");

    // the exit is opened by the finishing step
    a_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN_WB && !exit_reg) |=> exit_reg)
        else $error("exit not opened on finish");

endmodule

@@ sv/dfs_pick.sv @@
// Random neighbour choice of the maze carver.
// Counts open neighbours, scales the random word and selects the chosen one.
// Depends on dfs_pkg.
module dfs_pick (
    input  logic [3:0]         avail,
    input  logic [14:0]        word,
    output dfs_pkg::dfs_pick_t pick
);

    logic [2:0]  n;
    logic [17:0] prod;
    logic [1:0]  k;

    // index = (word * count) >> 15, kept below count
    always_comb
    begin
        n    = 3'($countones(avail));
        prod = 18'(word) * 18'(n);
        k    = prod[16:15];
        if (n != 3'd0 && {1'b0, k} >= n)
        begin
            k = 2'(n - 3'd1);
        end
    end

    // walk the open neighbours in N,S,E,W order to the k-th one
    always_comb
    begin
        logic [1:0] seen;
        logic       found;
        seen      = 2'd0;
        found     = 1'b0;
        pick.any  = (n != 3'd0);
        pick.dir  = dfs_pkg::DIR_N;
        for (int i = 0; i < 4; i++)
        begin
            if (avail[i] && !found)
            begin
                if (seen == k)
                begin
                    found    = 1'b1;
                    pick.dir = 2'(i);
                end
                seen = seen + 2'd1;
            end
        end
    end

endmodule

@@ tb/dfs_checker.sv @@
// Scoreboard for the depth-first maze carver: watches the command, result and
// register write channels, predicts each result and compares it field by field.
// Depends on dfs_pkg for the payload types, operation, direction and wall codes.
module dfs_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_ready,
    input  dfs_pkg::dfs_cmd_t cmd,
    input  logic              res_valid,
    input  logic              res_ready,
    input  dfs_pkg::dfs_res_t res,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [4:0]        cfg_data,
    output int                fails,
    output int                pending
);

    localparam int GRID_ROWS = 16;
    localparam int GRID_COLS = 16;
    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;

    // model of the maze: wall codes, path of visited cells, exit flag
    logic [3:0] walls [GRID_CELLS];
    logic [7:0] trail [GRID_CELLS];
    int         trail_depth;
    bit         exit_open;
    logic [4:0] rows_reg;
    logic [4:0] cols_reg;

    dfs_pkg::dfs_res_t expected_results [$];
    int                mismatch_count = 0;

    assign fails = mismatch_count;

    task automatic report(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [3:0] got,
                               input logic [3:0] want);
        if (got !== want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // register value as a grid dimension: zero acts as one, clipped at the grid size
    function automatic int unsigned span(input logic [4:0] v, input int unsigned limit);
        if (v == 5'd0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    function automatic void clear_maze();
        for (int i = 0; i < GRID_CELLS; i++)
        begin
            walls[i] = dfs_pkg::WALL_ALL;
            trail[i] = 8'd0;
        end
        walls[0] = dfs_pkg::WALL_START;
        trail_depth = 1;
        exit_open = 1'b0;
    endfunction

    // one carve step: backtrack to a cell with unvisited neighbours, then open one
    function automatic dfs_pkg::dfs_res_t carve_step(input logic [14:0] word);
        int unsigned       rows;
        int unsigned       cols;
        int unsigned       src;
        int unsigned       r;
        int unsigned       c;
        int unsigned       n;
        int unsigned       k;
        int unsigned       last;
        logic [1:0]        dirs [4];
        int unsigned       nbrs [4];
        bit                found;
        dfs_pkg::dfs_res_t out;

        rows = span(rows_reg, GRID_ROWS);
        cols = span(cols_reg, GRID_COLS);
        found = 1'b0;
        out = '0;
        src = 0;
        r = 0;
        c = 0;
        n = 0;
        while (trail_depth > 0 && !found)
        begin
            src = trail[trail_depth - 1];
            r = src / GRID_COLS;
            c = src % GRID_COLS;
            n = 0;
            if (r >= 1 && walls[src - GRID_COLS] == dfs_pkg::WALL_ALL)
            begin
                dirs[n] = dfs_pkg::DIR_N;
                nbrs[n] = src - GRID_COLS;
                n++;
            end
            if (r + 1 < rows && walls[src + GRID_COLS] == dfs_pkg::WALL_ALL)
            begin
                dirs[n] = dfs_pkg::DIR_S;
                nbrs[n] = src + GRID_COLS;
                n++;
            end
            if (c + 1 < cols && walls[src + 1] == dfs_pkg::WALL_ALL)
            begin
                dirs[n] = dfs_pkg::DIR_E;
                nbrs[n] = src + 1;
                n++;
            end
            if (c >= 1 && walls[src - 1] == dfs_pkg::WALL_ALL)
            begin
                dirs[n] = dfs_pkg::DIR_W;
                nbrs[n] = src - 1;
                n++;
            end
            if (n == 0)
                trail_depth--;
            else
                found = 1'b1;
        end

        if (found)
        begin
            // own wall is N >> dir, the facing wall of the neighbour is N >> (dir ^ 1)
            k = (int'(word) * n) >> 15;
            walls[src] = walls[src] & ~(dfs_pkg::WALL_N >> dirs[k]);
            walls[nbrs[k]] = walls[nbrs[k]] & ~(dfs_pkg::WALL_N >> (dirs[k] ^ 2'd1));
            if (trail_depth < GRID_CELLS)
            begin
                trail[trail_depth] = 8'(nbrs[k]);
                trail_depth++;
            end
            out.carved = 1'b1;
            out.from_row = 4'(r);
            out.from_col = 4'(c);
            out.direction = dirs[k];
            out.wall_code = walls[src];
        end
        else
        begin
            // maze complete: the exit through the south wall of the last cell opens once
            last = (rows - 1) * GRID_COLS + (cols - 1);
            if (!exit_open)
            begin
                walls[last] = walls[last] & ~dfs_pkg::WALL_S;
                exit_open = 1'b1;
            end
            out.finished = 1'b1;
            out.from_row = 4'(rows - 1);
            out.from_col = 4'(cols - 1);
            out.direction = dfs_pkg::DIR_S;
            out.wall_code = walls[last];
        end
        return out;
    endfunction

    function automatic dfs_pkg::dfs_res_t next_result(input dfs_pkg::dfs_cmd_t c);
        dfs_pkg::dfs_res_t out;
        out = '0;
        case (c.operation)
            dfs_pkg::OP_STEP:
                out = carve_step(c.random_word);
            dfs_pkg::OP_READ:
            begin
                out.finished = (trail_depth == 0);
                out.from_row = c.cell_row;
                out.from_col = c.cell_col;
                out.direction = dfs_pkg::DIR_N;
                out.wall_code = walls[{c.cell_row, c.cell_col}];
            end
            dfs_pkg::OP_RESTART:
            begin
                clear_maze();
                out.wall_code = dfs_pkg::WALL_START;
            end
            default:
                out.finished = (trail_depth == 0);
        endcase
        return out;
    endfunction

    // follow every transfer on the three channels
    always @(posedge clk or negedge rst_n)
    begin : watch
        dfs_pkg::dfs_res_t want;
        if (!rst_n)
        begin
            rows_reg = 5'd16;
            cols_reg = 5'd16;
            clear_maze();
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            // register write
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == dfs_pkg::CFG_ROWS)
                    rows_reg = cfg_data;
                else
                    cols_reg = cfg_data;
            end

            // command transfer
            if (cmd_valid && cmd_ready)
                expected_results = {expected_results, next_result(cmd)};

            // result transfer
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                    report("result transfer with no expected result waiting");
                else
                begin
                    want = expected_results.pop_front();
                    check_field("carved", res.carved, want.carved);
                    check_field("finished", res.finished, want.finished);
                    check_field("from_row", res.from_row, want.from_row);
                    check_field("from_col", res.from_col, want.from_col);
                    check_field("direction", res.direction, want.direction);
                    check_field("wall_code", res.wall_code, want.wall_code);
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// Testbench top for the depth-first maze carver: clock, reset, command stimulus,
// result back-pressure and the final verdict.
// Depends on dfs_pkg, dfs_maze_carver and dfs_checker.
module tb;

    // operation code that the block ignores
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam int CYCLE_LIMIT     = 4000000;
    localparam int RANDOM_ITEMS    = 1850;
    localparam int HOLD_OFF_AT     = 700;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 64;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_ready;
    dfs_pkg::dfs_cmd_t cmd = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    dfs_pkg::dfs_res_t res;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = dfs_pkg::CFG_ROWS;
    logic [4:0]        cfg_data = 5'd0;

    int fails;
    int pending;
    int items_sent = 0;
    int cycle_count = 0;
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;

    dfs_maze_carver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dfs_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // one command transfer after a random gap, valid held until taken
    task automatic send(input logic [1:0] op, input logic [14:0] word,
                        input logic [3:0] row, input logic [3:0] col);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 19);
        if (gap != 0)
            cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        cmd_valid <= 1'b1;
        cmd <= {op, word, row, col};
        do @(posedge clk); while (!cmd_ready);
        items_sent++;
    endtask

    // stop offering commands and wait for every result to come back
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // both dimension registers, back to back
    task automatic write_dims(input logic [4:0] rows, input logic [4:0] cols);
        cfg_valid <= 1'b1;
        cfg_index <= dfs_pkg::CFG_ROWS;
        cfg_data <= rows;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= dfs_pkg::CFG_COLS;
        cfg_data <= cols;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // mostly small mazes, some wide ones and out-of-range values
    function automatic logic [4:0] pick_dim();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 5'd0;
        if (sel == 1)
            return 5'($urandom_range(17, 31));
        if (sel == 2)
            return 5'd16;
        if (sel < 5)
            return 5'($urandom_range(7, 15));
        return 5'($urandom_range(1, 6));
    endfunction

    function automatic int dim_span(input logic [4:0] v);
        if (v == 5'd0)
            return 1;
        if (v > 5'd16)
            return 16;
        return int'(v);
    endfunction

    // run limit
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // result side: random stalls, one long hold-off to back the block up
    initial
    begin : receiver
        int gap;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                take_steady = !take_steady;
            gap = take_steady ? 0 : $urandom_range(0, 19);
            if (taken == HOLD_OFF_AT)
                gap = HOLD_OFF_CYCLES;
            if (gap != 0)
                res_ready <= 1'b0;
            repeat (gap) @(posedge clk);
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            taken++;
        end
    end

    // command side
    initial
    begin : stimulus
        int         random_goal;
        int         phase_len;
        int         sel;
        logic [1:0] op;
        logic [4:0] rows_v;
        logic [4:0] cols_v;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reads of corner cells, the ignored code, first carves on the full grid
        send(dfs_pkg::OP_READ, 15'h7fff, 4'd0, 4'd0);
        send(dfs_pkg::OP_READ, 15'h0000, 4'd15, 4'd15);
        send(OP_NONE, 15'h7fff, 4'd15, 4'd0);
        send(dfs_pkg::OP_STEP, 15'h0000, 4'd0, 4'd15);
        send(dfs_pkg::OP_STEP, 15'h7fff, 4'd0, 4'd0);
        send(dfs_pkg::OP_READ, 15'h0000, 4'd1, 4'd0);

        // shrink to one row of two without a restart, zero rows acts as one
        wait_idle();
        write_dims(5'd0, 5'd2);
        send(dfs_pkg::OP_STEP, 15'h4000, 4'd0, 4'd0);
        send(dfs_pkg::OP_RESTART, 15'h7fff, 4'd15, 4'd15);
        send(dfs_pkg::OP_STEP, 15'h7fff, 4'd0, 4'd0);
        send(dfs_pkg::OP_STEP, 15'h0000, 4'd0, 4'd0);
        send(dfs_pkg::OP_STEP, 15'h2aaa, 4'd0, 4'd0);
        send(dfs_pkg::OP_READ, 15'h7fff, 4'd0, 4'd1);
        send(OP_NONE, 15'h0000, 4'd0, 4'd0);

        // oversize row count clips to the grid, a single column
        wait_idle();
        write_dims(5'd31, 5'd1);
        send(dfs_pkg::OP_RESTART, 15'h0000, 4'd0, 4'd0);
        send(dfs_pkg::OP_STEP, 15'h0000, 4'd0, 4'd0);
        send(dfs_pkg::OP_STEP, 15'h7fff, 4'd0, 4'd0);
        send(dfs_pkg::OP_STEP, 15'h5555, 4'd0, 4'd0);
        send(dfs_pkg::OP_STEP, 15'h2aaa, 4'd0, 4'd0);

        // change bounds mid-run, stacked cells outside the new bounds stay put
        wait_idle();
        write_dims(5'd2, 5'd31);
        send(dfs_pkg::OP_STEP, 15'h7fff, 4'd0, 4'd0);
        send(dfs_pkg::OP_STEP, 15'h0000, 4'd0, 4'd0);
        send(dfs_pkg::OP_STEP, 15'h6000, 4'd0, 4'd0);
        send(dfs_pkg::OP_READ, 15'h0000, 4'd15, 4'd0);
        send(dfs_pkg::OP_READ, 15'h7fff, 4'd1, 4'd15);

        // random phases: new dimensions, usually a restart, then mostly carve steps
        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal)
        begin
            rows_v = pick_dim();
            cols_v = pick_dim();
            wait_idle();
            write_dims(rows_v, cols_v);
            if ($urandom_range(0, 9) != 0)
                send(dfs_pkg::OP_RESTART, 15'($urandom_range(0, 32767)),
                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            phase_len = dim_span(rows_v) * dim_span(cols_v) * 3 / 2 + $urandom_range(2, 10);
            // last phase stops at the item goal
            if (phase_len > random_goal - items_sent)
                phase_len = random_goal - items_sent;
            repeat (phase_len)
            begin
                sel = $urandom_range(0, 399);
                if (sel < 300)
                    op = dfs_pkg::OP_STEP;
                else if (sel < 360)
                    op = dfs_pkg::OP_READ;
                else if (sel < 399)
                    op = OP_NONE;
                else
                    op = dfs_pkg::OP_RESTART;
                send(op, 15'($urandom_range(0, 32767)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)));
            end
        end

        // drain and verdict
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ dfs_maze_carver.f @@
sv/dfs_pkg.sv
sv/dfs_pick.sv
sv/dfs_maze_carver.sv
tb/dfs_checker.sv
tb/tb.sv
